// File: rtl/v3r_pkg.sv
package v3r_pkg;

    localparam int COORD_W   = 32;   // Q16.16 vector component
    localparam int RATIO_W   = 20;   // Q4.16 index ratio
    localparam int LANES     = 3;    // x, y, z
    localparam int FRAC_W    = 16;
    localparam int DIV_REM_W = COORD_W + FRAC_W;   // |v| * 2^16
    localparam int QUOT_W    = FRAC_W + 1;         // |u| <= 1.0

endpackage

// File: rtl/v3r_in_if.sv
interface v3r_in_if import v3r_pkg::*;;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] incident_x;
    logic signed [COORD_W-1:0] incident_y;
    logic signed [COORD_W-1:0] incident_z;
    logic signed [COORD_W-1:0] normal_x;
    logic signed [COORD_W-1:0] normal_y;
    logic signed [COORD_W-1:0] normal_z;
    logic [RATIO_W-1:0]        index_ratio;

    modport source (
        output valid, incident_x, incident_y, incident_z,
        output normal_x, normal_y, normal_z, index_ratio,
        input  ready
    );

    modport sink (
        input  valid, incident_x, incident_y, incident_z,
        input  normal_x, normal_y, normal_z, index_ratio,
        output ready
    );

endinterface

// File: rtl/v3r_out_if.sv
interface v3r_out_if import v3r_pkg::*;;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] refracted_x;
    logic signed [COORD_W-1:0] refracted_y;
    logic signed [COORD_W-1:0] refracted_z;
    logic                      total_reflection;

    modport source (
        output valid, refracted_x, refracted_y, refracted_z, total_reflection,
        input  ready
    );

    modport sink (
        input  valid, refracted_x, refracted_y, refracted_z, total_reflection,
        output ready
    );

endinterface

// File: rtl/v3r_sqrt_cell.sv
// One result bit of a restoring integer square root.
module v3r_sqrt_cell #(
    parameter int W  = 64,
    parameter int K  = 31,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [W-1:0]    in_rem,
    input  logic [W/2-1:0]  in_root,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [W-1:0]    out_rem,
    output logic [W/2-1:0]  out_root,
    output logic [SW-1:0]   out_side
);

    localparam int RW = W + 1;
    localparam int HW = W / 2;

    logic            valid_reg;
    logic [W-1:0]    rem_reg, rem_next;
    logic [HW-1:0]   root_reg, root_next;
    logic [SW-1:0]   side_reg;
    logic [RW-1:0]   trial;
    logic            take;

    // (q + 2^K)^2 - q^2 = q * 2^(K+1) + 2^(2K)
    always_comb
    begin
        trial     = (RW'(in_root) << (K + 1)) + (RW'(1) << (2 * K));
        take      = {1'b0, in_rem} >= trial;
        rem_next  = take ? (in_rem - trial[W-1:0]) : in_rem;
        root_next = take ? (in_root | (HW'(1) << K)) : in_root;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

// File: rtl/v3r_div_cell.sv
// One quotient bit of a restoring divide, three lanes sharing a divisor.
module v3r_div_cell import v3r_pkg::*; #(
    parameter int K  = 16,
    parameter int SW = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [LANES-1:0][DIV_REM_W-1:0]     in_rem,
    input  logic [LANES-1:0][QUOT_W-1:0]        in_quot,
    input  logic [COORD_W-1:0]                  in_divisor,
    input  logic [SW-1:0]                       in_side,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [LANES-1:0][DIV_REM_W-1:0]     out_rem,
    output logic [LANES-1:0][QUOT_W-1:0]        out_quot,
    output logic [COORD_W-1:0]                  out_divisor,
    output logic [SW-1:0]                       out_side
);

    localparam int TW = DIV_REM_W + 1;

    logic                               valid_reg;
    logic [LANES-1:0][DIV_REM_W-1:0]    rem_reg, rem_next;
    logic [LANES-1:0][QUOT_W-1:0]       quot_reg, quot_next;
    logic [COORD_W-1:0]                 divisor_reg;
    logic [SW-1:0]                      side_reg;
    logic [TW-1:0]                      trial;

    always_comb
    begin
        trial = TW'(in_divisor) << K;
        for (int i = 0; i < LANES; i++)
        begin
            if ({1'b0, in_rem[i]} >= trial)
            begin
                rem_next[i]  = in_rem[i] - trial[DIV_REM_W-1:0];
                quot_next[i] = in_quot[i] | (QUOT_W'(1) << K);
            end
            else
            begin
                rem_next[i]  = in_rem[i];
                quot_next[i] = in_quot[i];
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            rem_reg     <= rem_next;
            quot_reg    <= quot_next;
            divisor_reg <= in_divisor;
            side_reg    <= in_side;
        end
    end

    assign out_valid   = valid_reg;
    assign out_rem     = rem_reg;
    assign out_quot    = quot_reg;
    assign out_divisor = divisor_reg;
    assign out_side    = side_reg;

endmodule

// File: rtl/vector3_refract.sv
// Throughput: one beat per cycle while the output side is ready; every stage and cell
// has its own valid bit and holds while the stage after it is full, so bubbles close
// up under a stall. The pipeline holds three cell chains: a 32-bit square root,
// a 17-bit divide and a 24-bit square root.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
module vector3_refract import v3r_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    v3r_in_if.sink     incident,
    v3r_out_if.source  refracted
);

    localparam int SQA_W = 64;
    localparam int SQA_N = SQA_W / 2;
    localparam int SQB_W = 48;
    localparam int SQB_N = SQB_W / 2;
    localparam int DIV_N = QUOT_W;

    localparam logic signed [63:0] MAX32    = 64'sd2147483647;
    localparam logic signed [63:0] MIN32    = -64'sd2147483648;
    localparam logic signed [47:0] TERM_CAP = 48'sh4000_0000_0000;

    typedef struct packed {
        logic [LANES-1:0][COORD_W-1:0] v;
        logic [LANES-1:0][COORD_W-1:0] n;
        logic [RATIO_W-1:0]            r;
    } side_a_t;

    typedef struct packed {
        logic [LANES-1:0][COORD_W-1:0] n;
        logic [RATIO_W-1:0]            r;
        logic [LANES-1:0]              neg;
        logic                          zero;
    } side_d_t;

    typedef struct packed {
        logic [LANES-1:0][47:0]        t1;
        logic [LANES-1:0][COORD_W-1:0] n;
        logic                          tir;
    } side_b_t;

    localparam int SIDE_A_W = $bits(side_a_t);
    localparam int SIDE_D_W = $bits(side_d_t);
    localparam int SIDE_B_W = $bits(side_b_t);

    function automatic logic [31:0] sat32(input logic signed [63:0] val);
        logic [31:0] res;
        if (val > MAX32)
            res = MAX32[31:0];
        else if (val < MIN32)
            res = MIN32[31:0];
        else
            res = val[31:0];
        return res;
    endfunction

    // ---------------- s1: squares of the incident components
    logic                              s1_valid_reg, s1_ready;
    logic [LANES-1:0][63:0]            s1_sq_reg;
    logic [LANES-1:0][COORD_W-1:0]     s1_v_reg, s1_n_reg;
    logic [RATIO_W-1:0]                s1_r_reg;
    logic [LANES-1:0][COORD_W-1:0]     in_v, in_n;
    logic signed [63:0]                sq_prod [LANES];

    always_comb
    begin
        in_v[0] = incident.incident_x;
        in_v[1] = incident.incident_y;
        in_v[2] = incident.incident_z;
        in_n[0] = incident.normal_x;
        in_n[1] = incident.normal_y;
        in_n[2] = incident.normal_z;
        for (int i = 0; i < LANES; i++)
        begin
            sq_prod[i] = $signed(in_v[i]) * $signed(in_v[i]);
        end
    end

    logic s2_ready;
    assign s1_ready       = !s1_valid_reg || s2_ready;
    assign incident.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= incident.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            for (int i = 0; i < LANES; i++)
                s1_sq_reg[i] <= sq_prod[i];
            s1_v_reg <= in_v;
            s1_n_reg <= in_n;
            s1_r_reg <= incident.index_ratio;
        end
    end

    // ---------------- s2: squared length (below 2^64)
    logic                          s2_valid_reg;
    logic [63:0]                   s2_len_sq_reg;
    side_a_t                       s2_side_reg;
    logic                          a_valid [SQA_N+1];
    logic                          a_ready [SQA_N+1];
    logic [SQA_W-1:0]              a_rem   [SQA_N+1];
    logic [SQA_N-1:0]              a_root  [SQA_N+1];
    logic [SIDE_A_W-1:0]           a_side  [SQA_N+1];

    assign s2_ready = !s2_valid_reg || a_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_len_sq_reg <= s1_sq_reg[0] + s1_sq_reg[1] + s1_sq_reg[2];
            s2_side_reg   <= '{v: s1_v_reg, n: s1_n_reg, r: s1_r_reg};
        end
    end

    // ---------------- length: square root chain
    assign a_valid[0] = s2_valid_reg;
    assign a_rem[0]   = s2_len_sq_reg;
    assign a_root[0]  = '0;
    assign a_side[0]  = s2_side_reg;

    for (genvar j = 0; j < SQA_N; j++)
    begin : g_len_sqrt
        v3r_sqrt_cell #(.W(SQA_W), .K(SQA_N - 1 - j), .SW(SIDE_A_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (a_valid[j]),
            .in_ready  (a_ready[j]),
            .in_rem    (a_rem[j]),
            .in_root   (a_root[j]),
            .in_side   (a_side[j]),
            .out_valid (a_valid[j+1]),
            .out_ready (a_ready[j+1]),
            .out_rem   (a_rem[j+1]),
            .out_root  (a_root[j+1]),
            .out_side  (a_side[j+1])
        );
    end

    // ---------------- normalise: divide chain
    logic                               d_valid [DIV_N+1];
    logic                               d_ready [DIV_N+1];
    logic [LANES-1:0][DIV_REM_W-1:0]    d_rem   [DIV_N+1];
    logic [LANES-1:0][QUOT_W-1:0]       d_quot  [DIV_N+1];
    logic [COORD_W-1:0]                 d_div   [DIV_N+1];
    logic [SIDE_D_W-1:0]                d_side  [DIV_N+1];
    side_a_t                            a_out;
    side_d_t                            d_in_side;
    logic [COORD_W-1:0]                 v_mag [LANES];

    assign a_out = a_side[SQA_N];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            v_mag[i]        = a_out.v[i][COORD_W-1] ? (COORD_W'(0) - a_out.v[i]) : a_out.v[i];
            d_rem[0][i]     = {v_mag[i], {FRAC_W{1'b0}}};
            d_in_side.neg[i] = a_out.v[i][COORD_W-1];
        end
        d_in_side.n    = a_out.n;
        d_in_side.r    = a_out.r;
        d_in_side.zero = (a_root[SQA_N] == '0);
    end

    assign d_valid[0]     = a_valid[SQA_N];
    assign a_ready[SQA_N] = d_ready[0];
    assign d_quot[0]      = '0;
    assign d_div[0]       = a_root[SQA_N];
    assign d_side[0]      = d_in_side;

    for (genvar j = 0; j < DIV_N; j++)
    begin : g_norm_div
        v3r_div_cell #(.K(DIV_N - 1 - j), .SW(SIDE_D_W)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_valid    (d_valid[j]),
            .in_ready    (d_ready[j]),
            .in_rem      (d_rem[j]),
            .in_quot     (d_quot[j]),
            .in_divisor  (d_div[j]),
            .in_side     (d_side[j]),
            .out_valid   (d_valid[j+1]),
            .out_ready   (d_ready[j+1]),
            .out_rem     (d_rem[j+1]),
            .out_quot    (d_quot[j+1]),
            .out_divisor (d_div[j+1]),
            .out_side    (d_side[j+1])
        );
    end

    // ---------------- s3: signed unit vector
    logic                              s3_valid_reg, s3_ready;
    logic [LANES-1:0][17:0]            s3_u_reg;
    logic [LANES-1:0][COORD_W-1:0]     s3_n_reg;
    logic [RATIO_W-1:0]                s3_r_reg;
    side_d_t                           d_out;
    logic [LANES-1:0][17:0]            u_next;
    logic                              s4_ready;

    assign d_out = d_side[DIV_N];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (d_out.zero)
                u_next[i] = '0;
            else if (d_out.neg[i])
                u_next[i] = 18'd0 - {1'b0, d_quot[DIV_N][i]};
            else
                u_next[i] = {1'b0, d_quot[DIV_N][i]};
        end
    end

    assign d_ready[DIV_N] = s3_ready;
    assign s3_ready       = !s3_valid_reg || s4_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_ready)
            s3_valid_reg <= d_valid[DIV_N];
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_u_reg <= u_next;
            s3_n_reg <= d_out.n;
            s3_r_reg <= d_out.r;
        end
    end

    // ---------------- s4: u_i * n_i
    logic                              s4_valid_reg;
    logic [LANES-1:0][49:0]            s4_un_reg;
    logic [LANES-1:0][17:0]            s4_u_reg;
    logic [LANES-1:0][COORD_W-1:0]     s4_n_reg;
    logic [RATIO_W-1:0]                s4_r_reg;
    logic signed [49:0]                un_prod [LANES];
    logic                              s5_ready;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            un_prod[i] = $signed(s3_u_reg[i]) * $signed(s3_n_reg[i]);
    end

    assign s4_ready = !s4_valid_reg || s5_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (s4_ready)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            for (int i = 0; i < LANES; i++)
                s4_un_reg[i] <= un_prod[i];
            s4_u_reg <= s3_u_reg;
            s4_n_reg <= s3_n_reg;
            s4_r_reg <= s3_r_reg;
        end
    end

    // ---------------- s5: cosine dt
    logic                              s5_valid_reg;
    logic [31:0]                       s5_dt_reg;
    logic [LANES-1:0][17:0]            s5_u_reg;
    logic [LANES-1:0][COORD_W-1:0]     s5_n_reg;
    logic [RATIO_W-1:0]                s5_r_reg;
    logic signed [51:0]                dot;
    logic signed [63:0]                dot_sh;
    logic                              s6_ready;

    always_comb
    begin
        dot    = $signed(s4_un_reg[0]) + $signed(s4_un_reg[1]) + $signed(s4_un_reg[2]);
        dot_sh = dot >>> FRAC_W;
    end

    assign s5_ready = !s5_valid_reg || s6_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (s5_ready)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready)
        begin
            s5_dt_reg <= sat32(dot_sh);
            s5_u_reg  <= s4_u_reg;
            s5_n_reg  <= s4_n_reg;
            s5_r_reg  <= s4_r_reg;
        end
    end

    // ---------------- s6: dt^2, r^2, dt * n_i
    logic                              s6_valid_reg;
    logic [63:0]                       s6_dtsq_reg;
    logic [39:0]                       s6_rr_reg;
    logic [LANES-1:0][63:0]            s6_dtn_reg;
    logic [LANES-1:0][17:0]            s6_u_reg;
    logic [LANES-1:0][COORD_W-1:0]     s6_n_reg;
    logic [RATIO_W-1:0]                s6_r_reg;
    logic signed [63:0]                dtsq_prod;
    logic [39:0]                       rr_prod;
    logic signed [63:0]                dtn_prod [LANES];
    logic                              s7_ready;

    always_comb
    begin
        dtsq_prod = $signed(s5_dt_reg) * $signed(s5_dt_reg);
        rr_prod   = s5_r_reg * s5_r_reg;
        for (int i = 0; i < LANES; i++)
            dtn_prod[i] = $signed(s5_dt_reg) * $signed(s5_n_reg[i]);
    end

    assign s6_ready = !s6_valid_reg || s7_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (s6_ready)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s6_ready)
        begin
            s6_dtsq_reg <= dtsq_prod;
            s6_rr_reg   <= rr_prod;
            for (int i = 0; i < LANES; i++)
                s6_dtn_reg[i] <= dtn_prod[i];
            s6_u_reg <= s5_u_reg;
            s6_n_reg <= s5_n_reg;
            s6_r_reg <= s5_r_reg;
        end
    end

    // ---------------- s7: w = 1 - dt^2 and tangential a_i, as sign and magnitude
    logic                              s7_valid_reg;
    logic                              s7_w_neg_reg;
    logic [46:0]                       s7_w_mag_reg;
    logic [39:0]                       s7_rr_reg;
    logic [LANES-1:0]                  s7_a_neg_reg;
    logic [LANES-1:0][46:0]            s7_a_mag_reg;
    logic [LANES-1:0][COORD_W-1:0]     s7_n_reg;
    logic [RATIO_W-1:0]                s7_r_reg;
    logic signed [48:0]                w_val;
    logic [48:0]                       w_negated;
    logic signed [63:0]                dtn_sh [LANES];
    logic signed [48:0]                a_val [LANES];
    logic [48:0]                       a_negated [LANES];
    logic                              s8_ready;

    always_comb
    begin
        w_val     = 49'sd65536 - $signed({1'b0, s6_dtsq_reg[63:FRAC_W]});
        w_negated = 49'd0 - w_val;
        for (int i = 0; i < LANES; i++)
        begin
            dtn_sh[i]    = $signed(s6_dtn_reg[i]) >>> FRAC_W;
            a_val[i]     = $signed(s6_u_reg[i]) - $signed(dtn_sh[i][47:0]);
            a_negated[i] = 49'd0 - a_val[i];
        end
    end

    assign s7_ready = !s7_valid_reg || s8_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else if (s7_ready)
            s7_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s7_ready)
        begin
            s7_w_neg_reg <= w_val[48];
            s7_w_mag_reg <= w_val[48] ? w_negated[46:0] : w_val[46:0];
            s7_rr_reg    <= s6_rr_reg;
            for (int i = 0; i < LANES; i++)
            begin
                s7_a_neg_reg[i] <= a_val[i][48];
                s7_a_mag_reg[i] <= a_val[i][48] ? a_negated[i][46:0] : a_val[i][46:0];
            end
            s7_n_reg <= s6_n_reg;
            s7_r_reg <= s6_r_reg;
        end
    end

    // ---------------- s8: partial products of r^2 * |w| and r * |a_i|
    logic                              s8_valid_reg;
    logic                              s8_w_neg_reg;
    logic [63:0]                       s8_pp_ll_reg;
    logic [46:0]                       s8_pp_lh_reg;
    logic [39:0]                       s8_pp_hl_reg;
    logic [22:0]                       s8_pp_hh_reg;
    logic [LANES-1:0][51:0]            s8_alo_reg;
    logic [LANES-1:0][34:0]            s8_ahi_reg;
    logic [LANES-1:0]                  s8_a_neg_reg;
    logic [LANES-1:0][COORD_W-1:0]     s8_n_reg;
    logic                              s9_ready;

    assign s8_ready = !s8_valid_reg || s9_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_valid_reg <= 1'b0;
        else if (s8_ready)
            s8_valid_reg <= s7_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s8_ready)
        begin
            s8_w_neg_reg <= s7_w_neg_reg;
            s8_pp_ll_reg <= s7_rr_reg[31:0] * s7_w_mag_reg[31:0];
            s8_pp_lh_reg <= s7_rr_reg[31:0] * s7_w_mag_reg[46:32];
            s8_pp_hl_reg <= s7_rr_reg[39:32] * s7_w_mag_reg[31:0];
            s8_pp_hh_reg <= s7_rr_reg[39:32] * s7_w_mag_reg[46:32];
            for (int i = 0; i < LANES; i++)
            begin
                s8_alo_reg[i] <= s7_a_mag_reg[i][31:0] * s7_r_reg;
                s8_ahi_reg[i] <= s7_a_mag_reg[i][46:32] * s7_r_reg;
            end
            s8_a_neg_reg <= s7_a_neg_reg;
            s8_n_reg     <= s7_n_reg;
        end
    end

    // ---------------- s9: sum the partial products
    logic                              s9_valid_reg;
    logic                              s9_w_neg_reg;
    logic [86:0]                       s9_prod_reg;
    logic [LANES-1:0][66:0]            s9_ap_reg;
    logic [LANES-1:0]                  s9_a_neg_reg;
    logic [LANES-1:0][COORD_W-1:0]     s9_n_reg;
    logic                              s10_ready;

    assign s9_ready = !s9_valid_reg || s10_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s9_valid_reg <= 1'b0;
        else if (s9_ready)
            s9_valid_reg <= s8_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s9_ready)
        begin
            s9_w_neg_reg <= s8_w_neg_reg;
            s9_prod_reg  <= 87'(s8_pp_ll_reg) + (87'(s8_pp_lh_reg) << 32)
                          + (87'(s8_pp_hl_reg) << 32) + (87'(s8_pp_hh_reg) << 64);
            for (int i = 0; i < LANES; i++)
                s9_ap_reg[i] <= 67'(s8_alo_reg[i]) + (67'(s8_ahi_reg[i]) << 32);
            s9_a_neg_reg <= s8_a_neg_reg;
            s9_n_reg     <= s8_n_reg;
        end
    end

    // ---------------- s10: discriminant, reflection flag, r * a_i
    logic                              s10_valid_reg;
    logic [30:0]                       s10_disc_reg;
    side_b_t                           s10_side_reg;
    logic signed [34:0]                disc_full;
    logic [32:0]                       disc_up;
    logic [30:0]                       disc_q;
    logic                              disc_tir;
    logic                              term_cap [LANES];
    logic signed [63:0]                term_sp [LANES];
    logic signed [63:0]                term_sh [LANES];
    logic [LANES-1:0][47:0]            t1_next;

    always_comb
    begin
        // w < 0: round the product up so that disc = 1 + ceil(r^2 |w|)
        disc_up = 33'(s9_prod_reg[63:32]) + 33'(|s9_prod_reg[31:0]);
        if (s9_w_neg_reg)
            disc_full = 35'sd65536 + $signed({2'b0, disc_up});
        else
            disc_full = 35'sd65536 - $signed({3'b0, s9_prod_reg[63:32]});
        disc_tir = !s9_w_neg_reg && (disc_full <= 35'sd0);
        if (s9_w_neg_reg && ((|s9_prod_reg[86:64]) || (disc_full > 35'sd2147483647)))
            disc_q = '1;
        else
            disc_q = disc_full[30:0];

        for (int i = 0; i < LANES; i++)
        begin
            term_cap[i] = s9_ap_reg[i] > (67'(1) << 62);
            term_sp[i]  = s9_a_neg_reg[i] ? (64'sd0 - $signed(s9_ap_reg[i][63:0]))
                                          : $signed(s9_ap_reg[i][63:0]);
            term_sh[i]  = term_sp[i] >>> FRAC_W;
            if (term_cap[i])
                t1_next[i] = s9_a_neg_reg[i] ? (48'sd0 - TERM_CAP) : TERM_CAP;
            else
                t1_next[i] = term_sh[i][47:0];
        end
    end

    logic b_ready_in;
    assign s10_ready = !s10_valid_reg || b_ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s10_valid_reg <= 1'b0;
        else if (s10_ready)
            s10_valid_reg <= s9_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s10_ready)
        begin
            s10_disc_reg <= disc_q;
            s10_side_reg <= '{t1: t1_next, n: s9_n_reg, tir: disc_tir};
        end
    end

    // ---------------- square root of the discriminant
    logic                          b_valid [SQB_N+1];
    logic                          b_ready [SQB_N+1];
    logic [SQB_W-1:0]              b_rem   [SQB_N+1];
    logic [SQB_N-1:0]              b_root  [SQB_N+1];
    logic [SIDE_B_W-1:0]           b_side  [SQB_N+1];

    assign b_valid[0] = s10_valid_reg;
    assign b_ready_in = b_ready[0];
    assign b_rem[0]   = {1'b0, s10_disc_reg, {FRAC_W{1'b0}}};
    assign b_root[0]  = '0;
    assign b_side[0]  = s10_side_reg;

    for (genvar j = 0; j < SQB_N; j++)
    begin : g_disc_sqrt
        v3r_sqrt_cell #(.W(SQB_W), .K(SQB_N - 1 - j), .SW(SIDE_B_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (b_valid[j]),
            .in_ready  (b_ready[j]),
            .in_rem    (b_rem[j]),
            .in_root   (b_root[j]),
            .in_side   (b_side[j]),
            .out_valid (b_valid[j+1]),
            .out_ready (b_ready[j+1]),
            .out_rem   (b_rem[j+1]),
            .out_root  (b_root[j+1]),
            .out_side  (b_side[j+1])
        );
    end

    // ---------------- s11: n_i * s
    logic                              s11_valid_reg, s11_ready;
    logic [LANES-1:0][56:0]            s11_ns_reg;
    logic [LANES-1:0][47:0]            s11_t1_reg;
    logic                              s11_tir_reg;
    side_b_t                           b_out;
    logic signed [56:0]                ns_prod [LANES];
    logic                              s12_ready;

    assign b_out = b_side[SQB_N];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            ns_prod[i] = $signed(b_out.n[i]) * $signed({1'b0, b_root[SQB_N]});
    end

    assign b_ready[SQB_N] = s11_ready;
    assign s11_ready      = !s11_valid_reg || s12_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s11_valid_reg <= 1'b0;
        else if (s11_ready)
            s11_valid_reg <= b_valid[SQB_N];
    end

    always_ff @(posedge clk)
    begin
        if (s11_ready)
        begin
            for (int i = 0; i < LANES; i++)
                s11_ns_reg[i] <= ns_prod[i];
            s11_t1_reg  <= b_out.t1;
            s11_tir_reg <= b_out.tir;
        end
    end

    // ---------------- s12: t1 - t2, saturate; output register
    logic                              s12_valid_reg;
    logic [LANES-1:0][COORD_W-1:0]     s12_res_reg;
    logic                              s12_tir_reg;
    logic signed [56:0]                t2_val [LANES];
    logic signed [63:0]                diff [LANES];
    logic [LANES-1:0][COORD_W-1:0]     res_next;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            t2_val[i]   = $signed(s11_ns_reg[i]) >>> FRAC_W;
            diff[i]     = $signed(s11_t1_reg[i]) - t2_val[i];
            res_next[i] = s11_tir_reg ? '0 : sat32(diff[i]);
        end
    end

    assign s12_ready = !s12_valid_reg || refracted.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s12_valid_reg <= 1'b0;
        else if (s12_ready)
            s12_valid_reg <= s11_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s12_ready)
        begin
            s12_res_reg <= res_next;
            s12_tir_reg <= s11_tir_reg;
        end
    end

    assign refracted.valid            = s12_valid_reg;
    assign refracted.refracted_x      = s12_res_reg[0];
    assign refracted.refracted_y      = s12_res_reg[1];
    assign refracted.refracted_z      = s12_res_reg[2];
    assign refracted.total_reflection = s12_tir_reg;

endmodule

// File: dv/tb_vector3_refract.sv
module tb_vector3_refract;
    import v3r_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 85;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic signed [COORD_W-1:0] ix, iy, iz, nx, ny, nz;
        logic [RATIO_W-1:0]        r;
    } ray_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x, y, z;
        logic                      tir;
    } bent_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    v3r_in_if  in_ch ();
    v3r_out_if out_ch ();

    vector3_refract dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .incident  (in_ch.sink),
        .refracted (out_ch.source)
    );

    always #2 clk = ~clk;

    bent_t bent_q[$];
    int    errors = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    quiet_cycles = 0;

    // ---------------- predictor ----------------
    function automatic longint fl16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint ratio_term(longint a, logic [63:0] r);
        logic [63:0] mag;
        longint p;
        mag = (a < 0) ? -a : a;
        if (r != 0 && mag > ((64'd1 << 62) / r))
            return (a < 0) ? -(64'sd1 <<< 46) : (64'sd1 <<< 46);
        p = mag * r;
        return fl16((a < 0) ? -p : p);
    endfunction

    function automatic bent_t refract_ray(ray_t ray);
        longint v[3], n[3], u[3];
        logic [63:0] sq, len, rr, r, mag, prod, up;
        longint dot, dt, w, disc, s, a, t1, t2;
        bent_t o;
        r = ray.r;
        v[0] = ray.ix; v[1] = ray.iy; v[2] = ray.iz;
        n[0] = ray.nx; n[1] = ray.ny; n[2] = ray.nz;
        sq = 0;
        for (int i = 0; i < 3; i++) sq = sq + v[i] * v[i];
        len = root64(sq);
        for (int i = 0; i < 3; i++) u[i] = (len == 0) ? v[i] : (v[i] * 65536) / longint'(len);
        dot = 0;
        for (int i = 0; i < 3; i++) dot = dot + u[i] * n[i];
        dt = clip32(fl16(dot));
        w = 65536 - ((dt * dt) >>> 16);
        rr = r * r;
        if (w >= 0)
            disc = 65536 - longint'((rr * w) >> 32);
        else
        begin
            mag = -w;
            if (rr != 0 && mag > (64'hFFFF_FFFF_FFFF_FFFF / rr))
                disc = 64'sd2147483647;
            else
            begin
                prod = rr * mag;
                up = (prod >> 32) + ((prod[31:0] != 0) ? 1 : 0);
                disc = 65536 + longint'(up);
            end
        end
        disc = clip32(disc);
        o = '0;
        if (disc <= 0)
        begin
            o.tir = 1'b1;
            return o;
        end
        s = root64(disc << 16);
        for (int i = 0; i < 3; i++)
        begin
            a = u[i] - fl16(dt * n[i]);
            t1 = ratio_term(a, r);
            t2 = fl16(n[i] * s);
            case (i)
                0: o.x = clip32(t1 - t2);
                1: o.y = clip32(t1 - t2);
                default: o.z = clip32(t1 - t2);
            endcase
        end
        return o;
    endfunction

    // ---------------- driving ----------------
    // valid stays high after a beat; it drops only while idling or when sending stops
    task automatic send_ray(ray_t ray);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.incident_x  <= ray.ix;
        in_ch.incident_y  <= ray.iy;
        in_ch.incident_z  <= ray.iz;
        in_ch.normal_x    <= ray.nx;
        in_ch.normal_y    <= ray.ny;
        in_ch.normal_z    <= ray.nz;
        in_ch.index_ratio <= ray.r;
        do @(posedge clk); while (!in_ch.ready);
        bent_q.push_back(refract_ray(ray));
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        bent_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            if (bent_q.size() == 0)
                report("unexpected beat", out_ch.refracted_x, 0);
            else
            begin
                want = bent_q.pop_front();
                if (out_ch.refracted_x !== want.x) report("x", out_ch.refracted_x, want.x);
                if (out_ch.refracted_y !== want.y) report("y", out_ch.refracted_y, want.y);
                if (out_ch.refracted_z !== want.z) report("z", out_ch.refracted_z, want.z);
                if (out_ch.total_reflection !== want.tir)
                    report("tir", out_ch.total_reflection, want.tir);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(131072) - 65536;
            2: return {$urandom} >>> $urandom_range(31);
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(400000)) - 200000;
        endcase
    endfunction

    function automatic ray_t rand_ray();
        ray_t ray;
        int axis;
        ray.ix = rand_coord(); ray.iy = rand_coord(); ray.iz = rand_coord();
        if ($urandom_range(3) != 0)
        begin
            // mostly unit axis normals
            axis = $urandom_range(2);
            ray.nx = (axis == 0) ? ($urandom_range(1) ? 65536 : -65536) : 0;
            ray.ny = (axis == 1) ? ($urandom_range(1) ? 65536 : -65536) : 0;
            ray.nz = (axis == 2) ? ($urandom_range(1) ? 65536 : -65536) : 0;
        end
        else
        begin
            ray.nx = rand_coord(); ray.ny = rand_coord(); ray.nz = rand_coord();
        end
        case ($urandom_range(3))
            0: ray.r = $urandom;
            1: ray.r = $urandom_range(98304, 45000);
            default: ray.r = $urandom_range(131072);
        endcase
        return ray;
    endfunction

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (bent_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic test_corners();
        ray_t ray;
        ray = '{0, 0, 0, 0, 0, 65536, 65536};                  // zero incident
        send_ray(ray);
        ray = '{0, 0, -65536, 0, 0, 65536, 65536};
        send_ray(ray);
        ray = '{65536, 0, -100, 0, 0, 65536, 20'hFFFFF};       // grazing, reflects
        send_ray(ray);
        ray = '{40000, 0, -40000, 0, 0, 65536, 98304};
        send_ray(ray);
        ray = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'hFFFFF}; // bad normal
        send_ray(ray);
        ray = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0};
        send_ray(ray);
        ray = '{0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1};
        send_ray(ray);
        ray = '{-1, 1, -1, 32'h0100_0000, 32'hFF00_0000, 7, 20'hFFFFF};
        send_ray(ray);
        ray = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'h55555};
        send_ray(ray);
        ray = '{32'h5555_5555, 32'hAAAA_AAAA, 1, 32'hAAAA_AAAA, 32'h5555_5555, 2,
                20'hAAAAA};
        send_ray(ray);
        // pause until the pipe is empty
        in_ch.valid <= 1'b0;
        while (bent_q.size() != 0) @(posedge clk);
    endtask

    task automatic test_random(int count, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) send_ray(rand_ray());
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.incident_x = '0; in_ch.incident_y = '0; in_ch.incident_z = '0;
        in_ch.normal_x = '0; in_ch.normal_y = '0; in_ch.normal_z = '0;
        in_ch.index_ratio = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random(250, 17, 48);
        test_random(250, 48, 17);
        test_random(250, 0, 0);
        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
rtl/v3r_pkg.sv
rtl/v3r_in_if.sv
rtl/v3r_out_if.sv
rtl/v3r_sqrt_cell.sv
rtl/v3r_div_cell.sv
rtl/vector3_refract.sv
dv/tb_vector3_refract.sv
